### rtl/core/pds_pkg.sv
// Shared types and sizes for the pairwise distance sort core.
// No dependencies; imported by every module of the core.
package pds_pkg;

  localparam int MAX_POINTS = 8;
  localparam int MAX_PAIRS  = MAX_POINTS * (MAX_POINTS - 1) / 2;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int PAIR_W     = $clog2(MAX_PAIRS + 1);
  localparam int PIDX_W     = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int COORD_W    = 16;
  localparam int DSQ_W      = 34;
  localparam int ROOT_W     = 25;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 3;
  localparam int SQC_W      = $clog2(ROOT_W);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] second;
    logic [DSQ_W-1:0] dsq;
  } pair_t;

  typedef struct packed {
    logic store;
    logic final_pt;
    logic rd_pair;
    logic mul;
    logic sum;
    logic ins;
    logic rd_emit;
    logic sqrt_step;
    logic next_k;
  } pds_cmd_t;

  typedef struct packed {
    logic ge2;
    logic pair_last;
    logic sqrt_done;
    logic emit_last;
  } pds_stat_t;

endpackage

### rtl/core/pairwise_distance_sort_core.sv
// Top level of the pairwise distance sort core.
// Depends on pds_pkg, pds_ctrl and pds_datapath.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    px, py, pz, final_point
//   out_     output     out_valid / out_stall  a*, b*, dist_squared, dist_fixed, last_pair
//
// Points are taken one per cycle while loading. After a final point with n stored
// points, each of the n(n-1)/2 pairs is read, squared, summed and inserted into
// the list, then each result has a store read, a 25-step square root and output.
// For n >= 2 the input stays stalled from the final point until the last result is taken.
// Synchronous reset returns to loading with an empty set; out_stall holds a result.
module pairwise_distance_sort_core import pds_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_px,
  input  logic signed [COORD_W-1:0] in_py,
  input  logic signed [COORD_W-1:0] in_pz,
  input  logic                      in_final_point,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_ax,
  output logic signed [COORD_W-1:0] out_ay,
  output logic signed [COORD_W-1:0] out_az,
  output logic signed [COORD_W-1:0] out_bx,
  output logic signed [COORD_W-1:0] out_by_coord,
  output logic signed [COORD_W-1:0] out_bz,
  output logic [DSQ_W-1:0]          out_dist_squared,
  output logic [ROOT_W-1:0]         out_dist_fixed,
  output logic                      out_last_pair
);

  pds_cmd_t  cmd;
  pds_stat_t stat;
  point_t    pa, pb;

  pds_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_final_point (in_final_point),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .stat           (stat),
    .cmd            (cmd)
  );

  pds_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_px    (in_px),
    .in_py    (in_py),
    .in_pz    (in_pz),
    .pa       (pa),
    .pb       (pb),
    .dsq_out  (out_dist_squared),
    .root_out (out_dist_fixed)
  );

  assign out_ax        = pa.x;
  assign out_ay        = pa.y;
  assign out_az        = pa.z;
  assign out_bx        = pb.x;
  assign out_by_coord  = pb.y;
  assign out_bz        = pb.z;
  assign out_last_pair = stat.emit_last;

endmodule

### rtl/core/pds_datapath.sv
// Datapath: point store, distance arithmetic, sorted pair list and square root.
// Depends on pds_pkg; driven by pds_ctrl through command and status structs.
module pds_datapath import pds_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pds_cmd_t                  cmd,
  output pds_stat_t                 stat,
  input  logic signed [COORD_W-1:0] in_px,
  input  logic signed [COORD_W-1:0] in_py,
  input  logic signed [COORD_W-1:0] in_pz,
  output point_t                    pa,
  output point_t                    pb,
  output logic [DSQ_W-1:0]          dsq_out,
  output logic [ROOT_W-1:0]         root_out
);

  point_t               store [MAX_POINTS];
  logic [CNT_W-1:0]     cnt_r, n_r, cnt_after;
  logic [IDX_W-1:0]     i_r, j_r;
  logic [PAIR_W-1:0]    np_r;
  logic [PIDX_W-1:0]    k_r;
  point_t               rda_r, rdb_r;
  logic [2*COORD_W-1:0] sq_r [3];
  logic [DSQ_W-1:0]     dsq_r;
  pair_t                list_r [MAX_PAIRS];
  pair_t                ins_e [MAX_PAIRS];
  pair_t                src_e [MAX_PAIRS];
  pair_t                new_e, cur_e;
  logic [MAX_PAIRS-1:0] gt;
  logic [RAD_W-1:0]     rad_r;
  logic [REM_W-1:0]     rem_r, sh, tr;
  logic [ROOT_W-1:0]    root_r;
  logic [SQC_W-1:0]     sqc_r;
  logic signed [COORD_W:0]   d [3];
  logic [COORD_W-1:0]        m [3];

  assign cnt_after = (cnt_r < CNT_W'(MAX_POINTS)) ? cnt_r + 1'b1 : cnt_r;
  assign cur_e     = list_r[k_r];

  assign stat.ge2       = (cnt_after >= CNT_W'(2));
  assign stat.pair_last = (CNT_W'(j_r) + 1'b1 == n_r) && (CNT_W'(i_r) + CNT_W'(2) == n_r);
  assign stat.sqrt_done = (sqc_r == SQC_W'(ROOT_W - 1));
  assign stat.emit_last = (PAIR_W'(k_r) + 1'b1 == np_r);

  assign pa       = rda_r;
  assign pb       = rdb_r;
  assign dsq_out  = cur_e.dsq;
  assign root_out = root_r;

  // Control counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      n_r   <= '0;
      i_r   <= '0;
      j_r   <= '0;
      np_r  <= '0;
      k_r   <= '0;
    end else begin
      if (cmd.store) begin
        cnt_r <= cnt_after;
      end
      if (cmd.final_pt) begin
        cnt_r <= '0;
        n_r   <= cnt_after;
        i_r   <= '0;
        j_r   <= IDX_W'(1);
        np_r  <= '0;
        k_r   <= '0;
      end
      if (cmd.ins) begin
        np_r <= np_r + 1'b1;
        if (CNT_W'(j_r) + 1'b1 == n_r) begin
          i_r <= i_r + 1'b1;
          j_r <= i_r + IDX_W'(2);
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      if (cmd.next_k) begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  // Point store with registered read ports.
  always_ff @(posedge clk) begin
    if (cmd.store && (cnt_r < CNT_W'(MAX_POINTS))) begin
      store[cnt_r[IDX_W-1:0]] <= '{x: in_px, y: in_py, z: in_pz};
    end
    if (cmd.rd_pair) begin
      rda_r <= store[i_r];
      rdb_r <= store[j_r];
    end else if (cmd.rd_emit) begin
      rda_r <= store[cur_e.first];
      rdb_r <= store[cur_e.second];
    end
  end

  // Per-axis absolute differences; magnitudes never exceed 16 bits.
  always_comb begin
    d[0] = $signed({rda_r.x[COORD_W-1], rda_r.x}) - $signed({rdb_r.x[COORD_W-1], rdb_r.x});
    d[1] = $signed({rda_r.y[COORD_W-1], rda_r.y}) - $signed({rdb_r.y[COORD_W-1], rdb_r.y});
    d[2] = $signed({rda_r.z[COORD_W-1], rda_r.z}) - $signed({rdb_r.z[COORD_W-1], rdb_r.z});
    for (int a = 0; a < 3; a++) begin
      m[a] = d[a][COORD_W] ? COORD_W'(-d[a]) : d[a][COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      for (int a = 0; a < 3; a++) begin
        sq_r[a] <= m[a] * m[a];
      end
    end
    if (cmd.sum) begin
      dsq_r <= DSQ_W'(sq_r[0]) + DSQ_W'(sq_r[1]) + DSQ_W'(sq_r[2]);
    end
  end

  // Stable insertion into the descending list: a new pair lands after all
  // entries whose distance is greater than or equal to its own.
  always_comb begin
    new_e = '{first: i_r, second: j_r, dsq: dsq_r};
    for (int e = 0; e < MAX_PAIRS; e++) begin
      gt[e] = (PAIR_W'(e) < np_r) && (list_r[e].dsq < dsq_r);
    end
    src_e[0]   = new_e;
    for (int e = 1; e < MAX_PAIRS; e++) begin
      src_e[e]   = gt[e-1] ? list_r[e-1] : new_e;
    end
    for (int e = 0; e < MAX_PAIRS; e++) begin
      if ((PAIR_W'(e) < np_r && !gt[e]) || PAIR_W'(e) > np_r) begin
        ins_e[e] = list_r[e];
      end else begin
        ins_e[e] = src_e[e];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      for (int e = 0; e < MAX_PAIRS; e++) begin
        list_r[e] <= ins_e[e];
      end
    end
  end

  // Restoring square root, one result bit per cycle.
  assign sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign tr = {1'b0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.rd_emit) begin
      rad_r  <= {cur_e.dsq, 16'b0};
      rem_r  <= '0;
      root_r <= '0;
      sqc_r  <= '0;
    end else if (cmd.sqrt_step) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      sqc_r <= sqc_r + 1'b1;
      if (sh >= tr) begin
        rem_r  <= sh - tr;
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= sh;
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

### rtl/core/pds_ctrl.sv
// Controller state machine for the pairwise distance sort core.
// Depends on pds_pkg; sequences pds_datapath through command and status.
module pds_ctrl import pds_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_final_point,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  pds_stat_t stat,
  output pds_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_LOAD = 8'b0000_0001,
    S_RD   = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_SUM  = 8'b0000_1000,
    S_INS  = 8'b0001_0000,
    S_ERD  = 8'b0010_0000,
    S_SQRT = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept, out_take;

  assign in_stall  = (state_r != S_LOAD);
  assign out_valid = (state_r == S_OUT);
  assign accept    = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  always_comb begin
    cmd           = '0;
    cmd.store     = accept;
    cmd.final_pt  = accept && in_final_point;
    cmd.rd_pair   = (state_r == S_RD);
    cmd.mul       = (state_r == S_MUL);
    cmd.sum       = (state_r == S_SUM);
    cmd.ins       = (state_r == S_INS);
    cmd.rd_emit   = (state_r == S_ERD);
    cmd.sqrt_step = (state_r == S_SQRT);
    cmd.next_k    = out_take && !stat.emit_last;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: if (accept && in_final_point && stat.ge2) state_nxt = S_RD;
      S_RD:   state_nxt = S_MUL;
      S_MUL:  state_nxt = S_SUM;
      S_SUM:  state_nxt = S_INS;
      S_INS:  state_nxt = stat.pair_last ? S_ERD : S_RD;
      S_ERD:  state_nxt = S_SQRT;
      S_SQRT: if (stat.sqrt_done) state_nxt = S_OUT;
      S_OUT: begin
        if (out_take) state_nxt = stat.emit_last ? S_LOAD : S_ERD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
